/* rtl/tlik_pkg.sv */
package tlik_pkg;

   localparam int ANGLE_W = 35;
   localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 35'sd3373259426;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int LEN_W       = 20;
   localparam int OFF_W       = 20;
   localparam int RATIO_W     = 24;
   localparam int COORD_W     = 22;
   localparam int RESULT_W    = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_UPPER_ARM_LENGTH     = 3'd0,
      REG_FOREARM_LENGTH       = 3'd1,
      REG_SHOULDER_ZERO_OFFSET = 3'd2,
      REG_ELBOW_ZERO_OFFSET    = 3'd3,
      REG_ELBOW_GEAR_RATIO     = 3'd4
   } reg_index_type;

   // atan(2^-i) in 2^-30 rad
   function automatic logic [29:0] atan_step(input int unsigned i);
      logic [29:0] v;
      case (i)
         0: v = 30'd843314857;
         1: v = 30'd497837829;
         2: v = 30'd263043837;
         3: v = 30'd133525159;
         4: v = 30'd67021687;
         5: v = 30'd33543516;
         6: v = 30'd16775851;
         7: v = 30'd8388437;
         8: v = 30'd4194283;
         9: v = 30'd2097149;
         10: v = 30'd1048576;
         default: begin
            if (i <= 30) v = 30'(64'd1 << (30 - i));
            else v = '0;
         end
      endcase
      return v;
   endfunction

endpackage

/* rtl/two_link_inverse_kinematics_unit.sv */
// Throughput: one transaction per cycle when not stalled; every step of the cosine
// divider, the square root, the three CORDIC units and the gear ratio divider is
// its own pipeline stage. The pipeline moves on unless its last stage and the output
// register both hold results and rsp_ready is low.
// Reset clears all valid bits and loads the register reset values; no clearing pass.
module two_link_inverse_kinematics_unit
   import tlik_pkg::*;
#(
   parameter int CORDIC_STEPS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_target_x,
   input  logic signed [COORD_W-1:0]  req_target_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RESULT_W-1:0] rsp_shoulder_motor_angle,
   output logic signed [RESULT_W-1:0] rsp_elbow_motor_angle,
   output logic                       rsp_out_of_reach,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int DIV_STEPS  = 31;
   localparam int SQRT_STEPS = 31;
   localparam int EDIV_STEPS = 39;
   localparam int THETA_W    = 34;
   localparam int ALPHA_W    = 54;
   localparam int BETA_W     = 48;

   localparam int ST_NUM  = 1;
   localparam int ST_MAG  = 2;
   localparam int ST_C    = ST_MAG + DIV_STEPS + 1;
   localparam int ST_CSQ  = ST_C + 1;
   localparam int ST_N    = ST_CSQ + 1;
   localparam int ST_PROD = ST_N + SQRT_STEPS + 1;
   localparam int ST_F1   = ST_PROD + CORDIC_STEPS + 2;
   localparam int ST_F2   = ST_F1 + 1;
   localparam int ST_OUT  = ST_F2 + EDIV_STEPS + 1;
   localparam int CL_LEN  = ST_PROD - ST_C + 1;

   localparam logic signed [31:0] C_ONE = 32'sd1073741824;

   logic [LEN_W-1:0]          upper_ff;
   logic [LEN_W-1:0]          forearm_ff;
   logic signed [OFF_W-1:0]   shoulder_off_ff;
   logic signed [OFF_W-1:0]   elbow_off_ff;
   logic [RATIO_W-1:0]        ratio_ff;
   logic [41:0]               lsq_ff;
   logic [40:0]               den_ff;

   logic                      en;
   logic                      out_en;
   logic [ST_OUT-1:0]         vld_ff;
   logic [ST_OUT-1:ST_C]      reach_ff;
   logic                      rsp_valid_ff;
   logic signed [RESULT_W-1:0] sh_out_ff;
   logic signed [RESULT_W-1:0] el_out_ff;
   logic                      reach_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff        <= 20'd51200;
         forearm_ff      <= 20'd51200;
         shoulder_off_ff <= '0;
         elbow_off_ff    <= '0;
         ratio_ff        <= 24'd65536;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_UPPER_ARM_LENGTH:     upper_ff        <= csr_write_data[LEN_W-1:0];
            REG_FOREARM_LENGTH:       forearm_ff      <= csr_write_data[LEN_W-1:0];
            REG_SHOULDER_ZERO_OFFSET: shoulder_off_ff <= $signed(csr_write_data[OFF_W-1:0]);
            REG_ELBOW_ZERO_OFFSET:    elbow_off_ff    <= $signed(csr_write_data[OFF_W-1:0]);
            REG_ELBOW_GEAR_RATIO:     ratio_ff        <= csr_write_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   logic [39:0] l1sq;
   logic [39:0] l2sq;
   logic [39:0] l1l2;
   assign l1sq = upper_ff * upper_ff;
   assign l2sq = forearm_ff * forearm_ff;
   assign l1l2 = upper_ff * forearm_ff;

   always_ff @(posedge clock) begin
      lsq_ff <= {2'b00, l1sq} + {2'b00, l2sq};
      den_ff <= {l1l2, 1'b0};
   end

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign en        = out_en || !vld_ff[ST_OUT-1];
   assign req_ready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= {vld_ff[ST_OUT-2:0], req_valid && req_ready};
         if (out_en) rsp_valid_ff <= vld_ff[ST_OUT-1];
      end
   end

   // squares and coordinate line
   logic signed [43:0]        tx_prod;
   logic signed [43:0]        ty_prod;
   logic [42:0]               txsq_ff;
   logic [42:0]               tysq_ff;
   logic signed [COORD_W-1:0] tx_ff [ST_PROD+1];
   logic signed [COORD_W-1:0] ty_ff [ST_PROD+1];

   assign tx_prod = req_target_x * req_target_x;
   assign ty_prod = req_target_y * req_target_y;

   always_ff @(posedge clock) begin
      if (en) begin
         txsq_ff  <= tx_prod[42:0];
         tysq_ff  <= ty_prod[42:0];
         tx_ff[0] <= req_target_x;
         ty_ff[0] <= req_target_y;
         for (int k = 1; k <= ST_PROD; k++) begin
            tx_ff[k] <= tx_ff[k-1];
            ty_ff[k] <= ty_ff[k-1];
         end
      end
   end

   logic signed [44:0] num_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= $signed({2'b00, txsq_ff}) + $signed({2'b00, tysq_ff})
                   - $signed({3'b000, lsq_ff});
      end
   end

   // cosine divider, one quotient bit a stage
   logic [44:0] mag;
   logic        clamp;
   logic [41:0] dv_rem_ff   [DIV_STEPS+1];
   logic [30:0] dv_q_ff     [DIV_STEPS+1];
   logic        dv_neg_ff   [DIV_STEPS+1];
   logic        dv_clamp_ff [DIV_STEPS+1];

   assign mag   = (num_ff < 0) ? 45'(-num_ff) : 45'(num_ff);
   assign clamp = (den_ff == '0) || (mag > {4'b0000, den_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]   <= clamp ? '0 : {1'b0, mag[40:0]};
         dv_q_ff[0]     <= '0;
         dv_neg_ff[0]   <= num_ff < 0;
         dv_clamp_ff[0] <= clamp;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [41:0] t;
      logic        ge;
      assign t  = (j == 0) ? dv_rem_ff[j] : {dv_rem_ff[j][40:0], 1'b0};
      assign ge = t >= {1'b0, den_ff};
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j+1]   <= ge ? t - {1'b0, den_ff} : t;
            dv_q_ff[j+1]     <= dv_q_ff[j] | (31'(ge) << (DIV_STEPS - 1 - j));
            dv_neg_ff[j+1]   <= dv_neg_ff[j];
            dv_clamp_ff[j+1] <= dv_clamp_ff[j];
         end
      end
   end

   // cosine, its square and the sine radicand
   logic [30:0]        cval;
   logic signed [31:0] c_in;
   logic signed [31:0] cl_ff [CL_LEN];
   logic [31:0]        cabs;
   logic [61:0]        csq_ff;

   assign cval = dv_clamp_ff[DIV_STEPS] ? 31'h40000000 : dv_q_ff[DIV_STEPS];
   assign c_in = dv_neg_ff[DIV_STEPS] ? -$signed({1'b0, cval}) : $signed({1'b0, cval});
   assign cabs = (cl_ff[0] < 0) ? 32'(-cl_ff[0]) : 32'(cl_ff[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         cl_ff[0] <= c_in;
         for (int k = 1; k < CL_LEN; k++) cl_ff[k] <= cl_ff[k-1];
         csq_ff <= cabs[30:0] * cabs[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         reach_ff[ST_C] <= dv_clamp_ff[DIV_STEPS];
         reach_ff[ST_OUT-1:ST_C+1] <= reach_ff[ST_OUT-2:ST_C];
      end
   end

   // square root, one result bit a stage
   logic [61:0] sq_n_ff [SQRT_STEPS+1];
   logic [61:0] sq_r_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0] <= (62'd1 << 60) - csq_ff;
         sq_r_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
      logic [61:0] trial;
      logic        ge;
      assign trial = sq_r_ff[k] + BIT;
      assign ge    = sq_n_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_n_ff[k+1] <= ge ? sq_n_ff[k] - trial : sq_n_ff[k];
            sq_r_ff[k+1] <= ge ? (sq_r_ff[k] >> 1) + BIT : sq_r_ff[k] >> 1;
         end
      end
   end

   // link products
   logic [30:0]        s_val;
   logic [50:0]        pa;
   logic signed [51:0] pb;
   logic [50:0]        pa_ff;
   logic signed [51:0] pb_ff;
   logic [30:0]        ps_ff;

   assign s_val = sq_r_ff[SQRT_STEPS][30:0];
   assign pa    = forearm_ff * s_val;
   assign pb    = $signed({1'b0, forearm_ff}) * cl_ff[CL_LEN-2];

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa;
         pb_ff <= pb;
         ps_ff <= s_val;
      end
   end

   logic signed [THETA_W-1:0] th_x;
   logic signed [THETA_W-1:0] th_y;
   logic signed [ALPHA_W-1:0] al_x;
   logic signed [ALPHA_W-1:0] al_y;
   logic signed [BETA_W-1:0]  be_x;
   logic signed [BETA_W-1:0]  be_y;
   logic signed [ANGLE_W-1:0] theta2;
   logic signed [ANGLE_W-1:0] alpha;
   logic signed [ANGLE_W-1:0] beta;

   assign th_x = THETA_W'(cl_ff[CL_LEN-1]);
   assign th_y = $signed({3'b000, ps_ff});
   assign al_x = $signed({4'b0000, upper_ff, 30'b0}) + ALPHA_W'(pb_ff);
   assign al_y = $signed({3'b000, pa_ff});
   assign be_x = $signed({{2{tx_ff[ST_PROD][COORD_W-1]}}, tx_ff[ST_PROD], 24'b0});
   assign be_y = $signed({{2{ty_ff[ST_PROD][COORD_W-1]}}, ty_ff[ST_PROD], 24'b0});

   tlik_cordic #(.WIDTH(THETA_W), .STEPS(CORDIC_STEPS)) u_theta (
      .clock (clock), .en (en), .x_in (th_x), .y_in (th_y), .angle (theta2)
   );

   tlik_cordic #(.WIDTH(ALPHA_W), .STEPS(CORDIC_STEPS)) u_alpha (
      .clock (clock), .en (en), .x_in (al_x), .y_in (al_y), .angle (alpha)
   );

   tlik_cordic #(.WIDTH(BETA_W), .STEPS(CORDIC_STEPS)) u_beta (
      .clock (clock), .en (en), .x_in (be_x), .y_in (be_y), .angle (beta)
   );

   // offsets
   logic signed [36:0] f1_sh_ff;
   logic signed [35:0] f1_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f1_sh_ff <= 37'(beta) - 37'(alpha)
                     - $signed({{3{shoulder_off_ff[OFF_W-1]}}, shoulder_off_ff, 14'b0})
                     + 37'sd8192;
         f1_d_ff  <= 36'(theta2) - $signed({{2{elbow_off_ff[OFF_W-1]}}, elbow_off_ff, 14'b0});
      end
   end

   // shoulder rounding, gear ratio divider
   logic signed [36:0]         sh_shift;
   logic signed [RESULT_W-1:0] sh_sat;
   logic [34:0]                dm;
   logic [25:0]                dvsr;
   logic [25:0]                ed_rem_ff  [EDIV_STEPS+1];
   logic [38:0]                ed_q_ff    [EDIV_STEPS+1];
   logic [38:0]                ed_nm_ff   [EDIV_STEPS+1];
   logic signed [RESULT_W-1:0] ed_sh_ff   [EDIV_STEPS+1];
   logic                       ed_neg_ff  [EDIV_STEPS+1];
   logic                       ed_zero_ff [EDIV_STEPS+1];

   assign sh_shift = f1_sh_ff >>> 14;
   assign sh_sat   = (sh_shift > 37'sd2147483647)  ? 32'sh7FFFFFFF :
                     (sh_shift < -37'sd2147483648) ? 32'sh80000000 :
                     sh_shift[RESULT_W-1:0];
   assign dm       = (f1_d_ff < 0) ? 35'(-f1_d_ff) : 35'(f1_d_ff);
   assign dvsr     = {1'b0, ratio_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         ed_rem_ff[0]  <= '0;
         ed_q_ff[0]    <= '0;
         ed_nm_ff[0]   <= {1'b0, dm, 3'b000} + {15'b0, ratio_ff};
         ed_sh_ff[0]   <= sh_sat;
         ed_neg_ff[0]  <= f1_d_ff < 0;
         ed_zero_ff[0] <= f1_d_ff == '0;
      end
   end

   for (genvar k = 0; k < EDIV_STEPS; k++) begin : g_ediv
      logic [25:0] t;
      logic        ge;
      assign t  = {ed_rem_ff[k][24:0], ed_nm_ff[k][EDIV_STEPS-1-k]};
      assign ge = t >= dvsr;
      always_ff @(posedge clock) begin
         if (en) begin
            ed_rem_ff[k+1]  <= ge ? t - dvsr : t;
            ed_q_ff[k+1]    <= ed_q_ff[k] | (39'(ge) << (EDIV_STEPS - 1 - k));
            ed_nm_ff[k+1]   <= ed_nm_ff[k];
            ed_sh_ff[k+1]   <= ed_sh_ff[k];
            ed_neg_ff[k+1]  <= ed_neg_ff[k];
            ed_zero_ff[k+1] <= ed_zero_ff[k];
         end
      end
   end

   logic [38:0]                q_fin;
   logic signed [RESULT_W-1:0] el_in;

   assign q_fin = ed_q_ff[EDIV_STEPS];

   always_comb begin
      if (ed_zero_ff[EDIV_STEPS]) begin
         el_in = '0;
      end else if (ed_neg_ff[EDIV_STEPS]) begin
         el_in = (q_fin > 39'd2147483648) ? 32'sh80000000 : $signed(32'd0 - q_fin[31:0]);
      end else begin
         el_in = (q_fin > 39'd2147483647) ? 32'sh7FFFFFFF : $signed(q_fin[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         sh_out_ff    <= ed_sh_ff[EDIV_STEPS];
         el_out_ff    <= el_in;
         reach_out_ff <= reach_ff[ST_OUT-1];
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_shoulder_motor_angle = sh_out_ff;
   assign rsp_elbow_motor_angle    = el_out_ff;
   assign rsp_out_of_reach         = reach_out_ff;

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_C] |-> (cl_ff[0] <= C_ONE) && (cl_ff[0] >= -C_ONE))
      else $error("cosine outside unit range");

   a_clamp_unit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_C] && reach_ff[ST_C] |-> (cl_ff[0] == C_ONE) || (cl_ff[0] == -C_ONE))
      else $error("clamped cosine not at unit magnitude");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_PROD-1] |-> sq_r_ff[SQRT_STEPS] <= 62'd1073741824)
      else $error("sine exceeds one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

endmodule

/* rtl/tlik_cordic.sv */
module tlik_cordic
   import tlik_pkg::*;
#(
   parameter int WIDTH = 34,
   parameter int STEPS = 20
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [WIDTH-1:0]   x_in,
   input  logic signed [WIDTH-1:0]   y_in,
   output logic signed [ANGLE_W-1:0] angle
);

   logic signed [WIDTH-1:0]   x_ff [STEPS+1];
   logic signed [WIDTH-1:0]   y_ff [STEPS+1];
   logic signed [ANGLE_W-1:0] z_ff [STEPS+1];
   logic                      zero_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= (y_in >= 0) ? ANGLE_PI : -ANGLE_PI;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ANGLE_W-1:0] STEP_ANGLE =
         $signed({{(ANGLE_W-30){1'b0}}, atan_step(i)});
      logic signed [WIDTH-1:0] xs;
      logic signed [WIDTH-1:0] ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] < 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - STEP_ANGLE;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + STEP_ANGLE;
            end
         end
      end
   end

   assign angle = zero_ff[STEPS] ? '0 : z_ff[STEPS];

endmodule
